>>> rtl/dlb_pkg.sv
// Package for the dense layer with bias: word types, commands, sizes.
// Used by dense_layer_bias_fwd_bwd_unit; depends on nothing.
package dlb_pkg;

    localparam int MaxIn     = 16;
    localparam int MaxOut    = 16;
    localparam int WDepth    = (MaxIn + 1) * MaxOut;
    localparam int WAddrW    = 9;
    localparam int InIdxW    = 4;
    localparam int OutIdxW   = 4;
    localparam int AccW      = 40;
    localparam int MulW      = 16;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_FWD    = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_DELTA  = 2'd3;

    localparam logic [1:0] REG_LR     = 2'd0;
    localparam logic [1:0] REG_IN     = 2'd1;
    localparam logic [1:0] REG_OUT    = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [8:0]        index;
        logic signed [15:0] value;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [3:0]        position;
        logic signed [15:0] result;
        logic              final_res;
    } t_out_word;

    // Round half up from Q16.24 sum to Q4.12 and saturate.
    function automatic logic signed [15:0] acc_to_q12(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] s;
        logic signed [AccW-13:0] q;
        begin
            s = a + AccW'(2048);
            q = s[AccW-1:12];
            if (q > 28'sd32767) acc_to_q12 = 16'sh7fff;
            else if (q < -28'sd32768) acc_to_q12 = -16'sh8000;
            else acc_to_q12 = q[15:0];
        end
    endfunction

endpackage

>>> rtl/dense_layer_bias_fwd_bwd_unit.sv
// Dense layer with bias: forward pass and SGD update, Q4.12 fixed point.
// Depends on dlb_pkg (types, commands, rounding function).
//
// Command 0, command 2 and non-last words only store their value. Sizes
// below are the clamped in_size and out_size. A forward run forms
// out_size results of in_size+1 products each; a delta run forms in_size
// propagated deltas of out_size products each, then updates all
// (in_size+1)*out_size weights. Each product takes a read, an operand load,
// 16 add steps and an accumulate; each weight update a read, two serial
// products and a write. A result word still waiting holds the next one back.
// Every product goes through one shift-and-add multiplier that retires one
// multiplier bit per cycle, and the weight store has one read and one write port.
module dense_layer_bias_fwd_bwd_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  dlb_pkg::t_in_word     i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output dlb_pkg::t_out_word    o_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_EMIT  = 8'b0000_1000,
        S_URD   = 8'b0001_0000,
        S_UMUL1 = 8'b0010_0000,
        S_UMUL2 = 8'b0100_0000,
        S_UWR   = 8'b1000_0000
    } t_state;

    // Configuration registers
    logic [15:0] r_lr;
    logic [4:0]  r_in_size, r_out_size;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= 16'd655;
            r_in_size <= 5'd16;
            r_out_size <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dlb_pkg::REG_LR:  r_lr <= i_cfg_data;
                dlb_pkg::REG_IN:  r_in_size <= i_cfg_data[4:0];
                dlb_pkg::REG_OUT: r_out_size <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective sizes, clamped to 1..16
    logic [4:0] ni, no;
    assign ni = (r_in_size == 5'd0) ? 5'd1 : (r_in_size > 5'd16) ? 5'd16 : r_in_size;
    assign no = (r_out_size == 5'd0) ? 5'd1 : (r_out_size > 5'd16) ? 5'd16 : r_out_size;

    // Storage
    logic signed [15:0] r_w [dlb_pkg::WDepth];
    logic signed [15:0] r_x [dlb_pkg::MaxIn];
    logic signed [15:0] r_d [dlb_pkg::MaxOut];
    logic signed [15:0] r_wrd;

    t_state r_state;
    logic        r_mode;              // 0 forward, 1 delta
    logic [4:0]  r_i, r_j;            // row, column counters
    logic [4:0]  r_bit;               // multiplier bit counter
    logic signed [dlb_pkg::AccW-1:0] r_acc;
    logic signed [31:0] r_mcand;      // shifted multiplicand
    logic [15:0] r_mplier;            // multiplier shift register
    logic signed [47:0] r_prod;       // product being built
    logic        r_msign;             // multiplier was negative
    logic        r_ovalid;
    dlb_pkg::t_out_word r_odata;

    logic [8:0] rd_addr;
    logic [8:0] r_waddr;
    logic       r_we;
    logic signed [15:0] r_wdat;

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    wire acc_in = i_valid && !o_stall;
    wire signed [15:0] xi = (r_i == ni) ? 16'sd4096 : r_x[r_i[3:0]];

    // Weight address for the current (row, column)
    assign rd_addr = {r_i[4:0], r_j[3:0]};

    // Weight memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (r_we) r_w[r_waddr] <= r_wdat;
        r_wrd <= r_w[rd_addr];
    end

    // Input and delta buffers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            if ((i_data.cmd == dlb_pkg::CMD_FWD || i_data.cmd == dlb_pkg::CMD_LOAD)
                && i_data.index < 9'd16)
                r_x[i_data.index[3:0]] <= i_data.value;
            if (i_data.cmd == dlb_pkg::CMD_DELTA && i_data.index < 9'd16)
                r_d[i_data.index[3:0]] <= i_data.value;
        end
    end

    // Sequencer and serial multiplier
    logic signed [47:0] addend;
    always_comb begin
        addend = r_mplier[0] ? 48'(r_mcand) : 48'sd0;
    end

    logic signed [63:0] upd_full;
    logic signed [47:0] upd_r;
    logic signed [17:0] wnew;
    always_comb begin
        upd_r = (r_prod + 48'sd134217728) >>> 28;
        wnew = 18'(r_wrd) - 18'(upd_r);
        upd_full = 64'(upd_r);
    end
    wire upd_big = (upd_full > 64'sd65535) || (upd_full < -64'sd65536);

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        if (i_data.cmd == dlb_pkg::CMD_WRITE) begin
                            if (i_data.index < 9'(dlb_pkg::WDepth)) begin
                                r_we <= 1'b1;
                                r_waddr <= i_data.index;
                                r_wdat <= i_data.value;
                            end
                        end else if (i_data.last && i_data.cmd != dlb_pkg::CMD_LOAD) begin
                            r_mode <= (i_data.cmd == dlb_pkg::CMD_DELTA);
                            r_i <= '0;
                            r_j <= '0;
                            r_acc <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // registered read: r_wrd holds the data of rd_addr in the next cycle
                    r_state <= S_MUL;
                    r_bit <= 5'd0;
                    r_prod <= '0;
                end
                S_MUL: begin
                    if (r_bit == 5'd0) begin
                        // load operands: weight times x or delta, serial on |mplier|
                        r_mcand <= 32'(r_wrd);
                        if (r_mode) begin
                            r_mplier <= r_d[r_j[3:0]][15] ? 16'(-r_d[r_j[3:0]])
                                                          : r_d[r_j[3:0]];
                            r_msign <= r_d[r_j[3:0]][15];
                        end else begin
                            r_mplier <= xi[15] ? 16'(-xi) : xi;
                            r_msign <= xi[15];
                        end
                        r_bit <= 5'd1;
                    end else if (r_bit != 5'd17) begin
                        r_prod <= r_prod + addend;
                        r_mcand <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        r_acc <= r_acc + (r_msign ? -40'(r_prod) : 40'(r_prod));
                        // advance inner index
                        if (!r_mode) begin
                            if (r_i == ni) r_state <= S_EMIT;
                            else begin r_i <= r_i + 5'd1; r_state <= S_RD; end
                        end else begin
                            if (r_j + 5'd1 == no) r_state <= S_EMIT;
                            else begin r_j <= r_j + 5'd1; r_state <= S_RD; end
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata.kind <= r_mode;
                        r_odata.result <= dlb_pkg::acc_to_q12(r_acc);
                        r_acc <= '0;
                        if (!r_mode) begin
                            r_odata.position <= r_j[3:0];
                            r_odata.final_res <= (r_j + 5'd1 == no);
                            r_i <= '0;
                            if (r_j + 5'd1 == no) r_state <= S_IDLE;
                            else begin r_j <= r_j + 5'd1; r_state <= S_RD; end
                        end else begin
                            r_odata.position <= r_i[3:0];
                            r_odata.final_res <= (r_i + 5'd1 == ni);
                            r_j <= '0;
                            if (r_i + 5'd1 == ni) begin
                                r_i <= '0;
                                r_state <= S_URD;
                            end else begin
                                r_i <= r_i + 5'd1;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_URD: begin
                    r_state <= S_UMUL1;
                    r_bit <= 5'd0;
                    r_prod <= '0;
                end
                S_UMUL1: begin
                    // delta * x_ext, serial over |x|
                    if (r_bit == 5'd0) begin
                        r_mcand <= 32'(r_d[r_j[3:0]]);
                        r_mplier <= xi[15] ? 16'(-xi) : xi;
                        r_msign <= xi[15];
                        r_bit <= 5'd1;
                    end else if (r_bit != 5'd17) begin
                        r_prod <= r_prod + addend;
                        r_mcand <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        r_mcand <= r_msign ? 32'(-r_prod) : 32'(r_prod);
                        r_mplier <= r_lr;
                        r_msign <= 1'b0;
                        r_prod <= '0;
                        r_bit <= 5'd1;
                        r_state <= S_UMUL2;
                    end
                end
                S_UMUL2: begin
                    // times learning rate, serial over its bits
                    if (r_bit != 5'd17) begin
                        r_prod <= r_prod + (r_mplier[0] ? 48'(r_mcand) <<< (r_bit - 5'd1)
                                                        : 48'sd0);
                        r_mplier <= r_mplier >> 1;
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        r_state <= S_UWR;
                    end
                end
                S_UWR: begin
                    r_we <= 1'b1;
                    r_waddr <= rd_addr;
                    if (upd_big)
                        r_wdat <= upd_full[63] ? 16'sh7fff : -16'sh8000;
                    else if (wnew > 18'sd32767) r_wdat <= 16'sh7fff;
                    else if (wnew < -18'sd32768) r_wdat <= -16'sh8000;
                    else r_wdat <= wnew[15:0];
                    if (r_j + 5'd1 == no) begin
                        r_j <= '0;
                        if (r_i == ni) r_state <= S_IDLE;
                        else begin r_i <= r_i + 5'd1; r_state <= S_URD; end
                    end else begin
                        r_j <= r_j + 5'd1;
                        r_state <= S_URD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // No new word is taken while the engine runs
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepted word while busy");
    // A held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result changed under stall");
    // Weight writes stay inside the store
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> (r_waddr < 9'(dlb_pkg::WDepth))) else $error("weight write out of range");
`endif

endmodule
